// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and by the sorted_priority_queue_decrease_key top level.
package spq_pkg;

    localparam int DEPTH  = 64;
    localparam int KEY_W  = 16;
    localparam int TAG_W  = 16;
    localparam int FUNC_W = 2;
    localparam int ST_W   = 2;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [FUNC_W-1:0] FN_PUSH    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_POP     = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REORDER = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef struct packed {
        logic gt;
        logic lt;
        logic teq;
    } t_flags;

    typedef enum logic [1:0] {
        SEL_KEEP = 2'd0,
        SEL_PREV = 2'd1,
        SEL_NEXT = 2'd2,
        SEL_NEW  = 2'd3
    } t_sel;

    typedef struct packed {
        logic cmp_en;
        logic shift_en;
        t_sel sel;
    } t_cell_ctl;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the queue: holds a key and tag, compares against the broadcast beat.
// Depends on spq_pkg.
module spq_cell (
    input  logic                      i_clk,
    input  spq_pkg::t_cell_ctl        i_ctl,
    input  logic [spq_pkg::KEY_W-1:0] i_key,
    input  logic [spq_pkg::TAG_W-1:0] i_tag,
    input  spq_pkg::t_entry           i_prev,
    input  spq_pkg::t_entry           i_next,
    output spq_pkg::t_entry           o_entry,
    output spq_pkg::t_flags           o_flags
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    t_flags r_flags;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.sel)
            SEL_KEEP: n_entry = r_entry;
            SEL_PREV: n_entry = i_prev;
            SEL_NEXT: n_entry = i_next;
            SEL_NEW: begin
                n_entry.key = i_key;
                n_entry.tag = i_tag;
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_en) begin
            r_entry <= n_entry;
        end
        if (i_ctl.cmp_en) begin
            r_flags.gt  <= r_entry.key > i_key;
            r_flags.lt  <= r_entry.key < i_key;
            r_flags.teq <= r_entry.tag == i_tag;
        end
    end

    assign o_entry = r_entry;
    assign o_flags = r_flags;

endmodule

// ===== rtl/sorted_priority_queue_decrease_key.sv =====
// Sorted priority queue with reorder: a chain of spq_cell slots kept in key order.
// Push and pop: compare in every cell, then shift once the result register has room.
// Reorder: compare, locate the first tag match, then shift.
// One beat is in flight at a time; the result register frees the input side.
// Reset (synchronous, active low) empties the queue and the result register.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue_decrease_key (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [spq_pkg::FUNC_W-1:0] i_func,
    input  logic [15:0]                i_priority_req,
    input  logic [15:0]                i_tag,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [15:0]                o_out_tag,
    output logic [15:0]                o_out_priority,
    output logic [spq_pkg::ST_W-1:0]   o_status,
    output logic [spq_pkg::CNT_W-1:0]  o_count
);
    import spq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FIND  = 3'b010,
        S_SHIFT = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [FUNC_W-1:0]  r_func;
    logic [KEY_W-1:0]   r_key;
    logic [TAG_W-1:0]   r_tag;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [DEPTH-1:0]   r_first, r_le, r_ge;
    logic               r_up, r_found;
    logic               r_out_valid, n_out_valid;
    logic [TAG_W-1:0]   r_out_tag, n_out_tag;
    logic [KEY_W-1:0]   r_out_prio, n_out_prio;
    logic [ST_W-1:0]    r_status, n_status;
    logic [CNT_W-1:0]   r_out_count;

    t_entry             w_ent [DEPTH];
    t_flags             w_flg [DEPTH];
    t_cell_ctl          w_ctl [DEPTH];
    logic [DEPTH-1:0]   w_valid, w_gv, w_lv, w_m, w_first, w_minus;
    logic [KEY_W-1:0]   w_old;
    logic               w_accept, w_proceed, w_shift_ok;

    assign w_accept  = i_valid && o_ready;
    assign w_proceed = (r_state == S_SHIFT) && (!r_out_valid || i_ready);

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_valid[i] = CNT_W'(i) < r_count;
            w_gv[i]    = w_flg[i].gt && w_valid[i];
            w_lv[i]    = w_flg[i].lt && w_valid[i];
            w_m[i]     = w_flg[i].teq && w_valid[i];
        end
        w_first = w_m & (~w_m + DEPTH'(1));
        w_minus = w_first - DEPTH'(1);
        w_old   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_old = w_old | (w_ent[i].key & {KEY_W{w_first[i]}});
        end
    end

    always_comb begin
        n_status   = ST_OK;
        n_count    = r_count;
        n_out_tag  = '0;
        n_out_prio = '0;
        case (r_func)
            FN_PUSH: begin
                if (r_count >= CNT_W'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            FN_POP: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count    = r_count - CNT_W'(1);
                    n_out_tag  = w_ent[0].tag;
                    n_out_prio = w_ent[0].key;
                end
            end
            FN_REORDER: begin
                if (!r_found) begin
                    n_status = ST_NOTFOUND;
                end
            end
            default: n_status = ST_OK;
        endcase
        w_shift_ok = w_proceed && (n_status == ST_OK);
    end

    always_comb begin
        logic gp, ln;
        for (int i = 0; i < DEPTH; i++) begin
            gp = (i > 0) ? w_gv[(i > 0) ? i - 1 : 0] : 1'b0;
            ln = (i < DEPTH - 1) ? w_lv[(i < DEPTH - 1) ? i + 1 : i] : 1'b0;
            w_ctl[i].cmp_en   = w_accept;
            w_ctl[i].shift_en = w_shift_ok;
            w_ctl[i].sel      = SEL_KEEP;
            case (r_func)
                FN_PUSH: begin
                    if (gp) begin
                        w_ctl[i].sel = SEL_PREV;
                    end else if (w_gv[i] || (CNT_W'(i) == r_count)) begin
                        w_ctl[i].sel = SEL_NEW;
                    end
                end
                FN_POP: w_ctl[i].sel = SEL_NEXT;
                FN_REORDER: begin
                    if (r_up) begin
                        if (r_le[i]) begin
                            if (gp) begin
                                w_ctl[i].sel = SEL_PREV;
                            end else if (w_gv[i] || r_first[i]) begin
                                w_ctl[i].sel = SEL_NEW;
                            end
                        end
                    end else begin
                        if (r_ge[i]) begin
                            if (ln) begin
                                w_ctl[i].sel = SEL_NEXT;
                            end else if (r_first[i] || w_lv[i]) begin
                                w_ctl[i].sel = SEL_NEW;
                            end
                        end
                    end
                end
                default: w_ctl[i].sel = SEL_KEEP;
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_prev, w_next;
        if (g == 0) begin : g_head
            assign w_prev = '0;
        end else begin : g_mid
            assign w_prev = w_ent[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_body
            assign w_next = w_ent[g+1];
        end
        spq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_key   (r_state == S_IDLE ? i_priority_req : r_key),
            .i_tag   (r_state == S_IDLE ? i_tag : r_tag),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_entry (w_ent[g]),
            .o_flags (w_flg[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_func == FN_REORDER) ? S_FIND : S_SHIFT;
                end
            end
            S_FIND: n_state = S_SHIFT;
            S_SHIFT: begin
                if (w_proceed) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_proceed) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_func;
            r_key  <= i_priority_req;
            r_tag  <= i_tag;
        end
        if (r_state == S_FIND) begin
            r_first <= w_first;
            r_le    <= w_first | w_minus;
            r_ge    <= ~w_minus;
            r_found <= |w_m;
            r_up    <= r_key < w_old;
        end
        if (w_proceed) begin
            r_out_tag   <= n_out_tag;
            r_out_prio  <= n_out_prio;
            r_status    <= n_status;
            r_out_count <= n_count;
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_out_tag      = r_out_tag;
    assign o_out_priority = r_out_prio;
    assign o_status       = r_status;
    assign o_count        = r_out_count;

endmodule
